// ----- rtl/normal_cdf_approximation_defines.svh -----
// Assertion macros used by the checker file of the normal CDF block.
// No dependencies.
`ifndef NORMAL_CDF_APPROXIMATION_DEFINES_SVH
`define NORMAL_CDF_APPROXIMATION_DEFINES_SVH

// Overlapping implication, switched off while reset is high.
`define NCDF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, live during reset as well.
`define NCDF_ASSERT_NXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ncdf_pkg.sv -----
// Constants, stage map and pipeline record types of the normal CDF block.
// No dependencies.
package ncdf_pkg;

   localparam int IN_FRAC  = 12;
   localparam int A_BITS   = 15;
   localparam int SQ_SHIFT = 32 - 2 * IN_FRAC - 1;
   localparam int K_BITS   = 31;

   localparam logic [32:0] A_LIMIT  = 33'(8 << IN_FRAC);
   localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
   localparam logic [32:0] HALF_Q32 = 33'h0_8000_0000;

   localparam logic [63:0] BILLION = 64'd1000000000;
   localparam logic [31:0] P_Q32 =
      32'(((64'd2316419 << 32) + 64'd5000000) / 64'd10000000);
   localparam logic [31:0] INV_SQRT_2PI =
      32'(((64'd3989422804 << 32) + 64'd5000000000) / 64'd10000000000);
   localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

   localparam logic signed [35:0] COEF_B1 =
      36'(((64'd319381530 << 30) + BILLION / 2) / BILLION);
   localparam logic signed [35:0] COEF_B2 =
      36'(64'd0 - (((64'd356563782 << 30) + BILLION / 2) / BILLION));
   localparam logic signed [35:0] COEF_B3 =
      36'(((64'd1781477937 << 30) + BILLION / 2) / BILLION);
   localparam logic signed [35:0] COEF_B4 =
      36'(64'd0 - (((64'd1821255978 << 30) + BILLION / 2) / BILLION));
   localparam logic signed [35:0] COEF_B5 =
      36'(((64'd1330274429 << 30) + BILLION / 2) / BILLION);

   localparam int HRN_STEPS = 5;
   localparam logic signed [35:0] HORNER_ADD [HRN_STEPS] =
      '{COEF_B4, COEF_B3, COEF_B2, COEF_B1, 36'sd0};

   // stage map
   localparam int ST_DIV0   = 3;
   localparam int ST_HRN0   = ST_DIV0 + K_BITS;
   localparam int ST_LN0    = 2;
   localparam int LN_STEPS  = 6;
   localparam int ST_TAY0   = ST_LN0 + LN_STEPS;
   localparam int TAY_TERMS = 15;
   localparam int ST_SHF    = ST_TAY0 + 3 * TAY_TERMS;
   localparam int ST_PHI    = ST_SHF + 1;
   localparam int ST_TAIL   = ST_PHI + 1;
   localparam int ST_N32    = ST_TAIL + 1;
   localparam int ST_OUT    = ST_N32 + 1;
   localparam int PIPE_LATENCY = ST_OUT + 1;

   typedef struct packed {
      logic              neg;
      logic              zero;
      logic              big;
      logic [A_BITS-1:0] a;
   } cm_type;

   typedef struct packed {
      logic [33:0]        d;
      logic [33:0]        rem;
      logic [K_BITS-1:0]  k;
      logic signed [35:0] h;
      logic [65:0]        prod;
      logic               prod_neg;
   } dv_type;

   typedef struct packed {
      logic [36:0]        rm;
      logic [5:0]         n;
      logic [32:0]        term;
      logic [31:0]        p;
      logic [63:0]        pm;
      logic [66:0]        pm2;
      logic signed [35:0] sum;
      logic [32:0]        expv;
      logic [31:0]        phi;
   } ex_type;

endpackage

// ----- rtl/normal_cdf_approximation.sv -----
// Standard normal CDF N(x), Abramowitz-Stegun 26.2.17, as a fixed pipeline.
// Depends on ncdf_pkg.
//
// Usage:
//   Drive req_x_value (signed, 12 fraction bits) and raise start; the beat is
//   taken at any edge where start is high and busy is low. busy is high only
//   while reset is held, so one argument can be taken in every cycle.
//   Each result appears on rsp_probability (unsigned Q0.OUT_WIDTH) with
//   rsp_strobe high for exactly one cycle, in order of arrival. Throughput is
//   one result per cycle.
//   Latency is set by the exponent path: a squaring stage, a six-step range
//   reduction by ln2, a fifteen-term series, three stages a term (multiply,
//   reciprocal multiply for the divide by the term index, correct and
//   accumulate), then the shift by n and the density product.
//   The 31 one-bit steps of the reciprocal k = 1/(1+p|x|) and the Horner
//   evaluation run alongside and finish earlier; tail product, complement
//   and rounding close the pipe.
//   Reset (synchronous) drops every beat in flight; nothing else is kept.
//   The receiver cannot stall, so the pipe never holds.
module normal_cdf_approximation #(
   parameter int IN_WIDTH  = 16,
   parameter int OUT_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [IN_WIDTH-1:0]  req_x_value,
   output logic                        rsp_strobe,
   output logic [OUT_WIDTH-1:0]        rsp_probability
);
   import ncdf_pkg::*;

   localparam int          OUT_SHIFT = 32 - OUT_WIDTH;
   localparam logic [33:0] RND_BIAS  = (34'd1 << OUT_SHIFT) >> 1;
   localparam logic [33:0] OUT_MAX   = (34'd1 << OUT_WIDTH) - 34'd1;
   localparam logic [66:0] HRN_RND   = 67'd1 << 29;

   logic [ST_OUT:0]     vld_ff;
   logic                accept;
   logic [IN_WIDTH-1:0] x_bits;
   logic [IN_WIDTH-1:0] x_abs;
   logic [32:0]         a_ext;
   cm_type              cm_in;
   cm_type              cm_ff [0:ST_TAIL];
   dv_type              dv_in [1:ST_PHI];
   dv_type              dv_ff [1:ST_PHI];
   ex_type              ex_in [1:ST_PHI];
   ex_type              ex_ff [1:ST_PHI];
   logic [34:0]         h_pos;
   logic [66:0]         tail_prod_in, tail_prod_ff;
   logic [32:0]         n32_in, n32_ff;
   logic [OUT_WIDTH-1:0] prob_in, prob_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   assign x_bits = req_x_value;
   assign x_abs  = x_bits[IN_WIDTH-1] ? (~x_bits + 1'b1) : x_bits;
   assign a_ext  = 33'(x_abs);

   always_comb begin
      cm_in.neg  = x_bits[IN_WIDTH-1];
      cm_in.zero = (x_bits == '0);
      cm_in.big  = (a_ext >= A_LIMIT);
      cm_in.a    = a_ext[A_BITS-1:0];
   end

   for (genvar s = 1; s <= ST_PHI; s++) begin : g_stage
      // reciprocal and Horner lane
      if (s == 1) begin : g_dv_t
         always_comb begin
            logic [46:0] tprod;
            logic [35:0] t;
            tprod = 47'(P_Q32) * 47'(cm_ff[0].a);
            t = 36'((48'(tprod) + 48'd2048) >> IN_FRAC);
            dv_in[s] = '0;
            dv_in[s].d = 34'(36'(ONE_Q32) + t);
            dv_in[s].h = COEF_B5;
         end
      end else if (s == 2) begin : g_dv_init
         always_comb begin
            dv_in[s] = dv_ff[s-1];
            // top of 2^62 + d/2 sits below d, so the quotient needs K_BITS steps
            dv_in[s].rem = 34'(HALF_Q32) + 34'(dv_ff[s-1].d[33:32]);
            dv_in[s].k = '0;
         end
      end else if (s >= ST_DIV0 && s < ST_HRN0) begin : g_dv_div
         localparam int DB = K_BITS - 1 - (s - ST_DIV0);
         always_comb begin
            logic [34:0] trial;
            trial = {dv_ff[s-1].rem, dv_ff[s-1].d[DB+1]};
            dv_in[s] = dv_ff[s-1];
            if (trial >= {1'b0, dv_ff[s-1].d}) begin
               dv_in[s].rem = 34'(trial - {1'b0, dv_ff[s-1].d});
               dv_in[s].k[DB] = 1'b1;
            end else begin
               dv_in[s].rem = trial[33:0];
               dv_in[s].k[DB] = 1'b0;
            end
         end
      end else if (s >= ST_HRN0 && s < ST_HRN0 + 2 * HRN_STEPS) begin : g_dv_hrn
         localparam int HJ  = (s - ST_HRN0) / 2;
         localparam int HPH = (s - ST_HRN0) % 2;
         if (HPH == 0) begin : g_mul
            always_comb begin
               logic [35:0] mag;
               mag = dv_ff[s-1].h[35] ? 36'(-dv_ff[s-1].h) : 36'(dv_ff[s-1].h);
               dv_in[s] = dv_ff[s-1];
               dv_in[s].prod_neg = dv_ff[s-1].h[35];
               dv_in[s].prod = 66'(mag[34:0]) * 66'(dv_ff[s-1].k);
            end
         end else begin : g_add
            always_comb begin
               logic signed [35:0] ps;
               ps = $signed(36'((67'(dv_ff[s-1].prod) + HRN_RND) >> 30));
               dv_in[s] = dv_ff[s-1];
               // round the magnitude, then put the sign back
               dv_in[s].h = HORNER_ADD[HJ] + (dv_ff[s-1].prod_neg ? -ps : ps);
            end
         end
      end else begin : g_dv_hold
         assign dv_in[s] = dv_ff[s-1];
      end

      // exponent and density lane
      if (s == 1) begin : g_ex_sq
         always_comb begin
            ex_in[s] = '0;
            ex_in[s].rm = 37'(30'(cm_ff[0].a) * 30'(cm_ff[0].a)) << SQ_SHIFT;
            ex_in[s].n = '0;
            ex_in[s].term = ONE_Q32;
            ex_in[s].sum = $signed(36'(ONE_Q32));
         end
      end else if (s >= ST_LN0 && s < ST_TAY0) begin : g_ex_ln
         localparam int LB = LN_STEPS - 1 - (s - ST_LN0);
         always_comb begin
            logic [36:0] lim;
            lim = 37'(LN2_Q32) << LB;
            ex_in[s] = ex_ff[s-1];
            if (ex_ff[s-1].rm >= lim) begin
               ex_in[s].rm = ex_ff[s-1].rm - lim;
               ex_in[s].n[LB] = 1'b1;
            end
         end
      end else if (s >= ST_TAY0 && s < ST_SHF) begin : g_ex_tay
         localparam int TJ  = (s - ST_TAY0) / 3 + 1;
         localparam int TPH = (s - ST_TAY0) % 3;
         localparam logic [34:0] RECIP = 35'((64'd1 << 34) / 64'(TJ));
         localparam bit T_SUB = (TJ % 2) == 1;
         if (TPH == 0) begin : g_mul
            always_comb begin
               logic [64:0] prod65;
               prod65 = 65'(ex_ff[s-1].term) * 65'(ex_ff[s-1].rm[31:0]);
               ex_in[s] = ex_ff[s-1];
               ex_in[s].pm = prod65[63:0];
            end
         end else if (TPH == 1) begin : g_rcp
            always_comb begin
               ex_in[s] = ex_ff[s-1];
               ex_in[s].p = ex_ff[s-1].pm[63:32];
               ex_in[s].pm2 = 67'(ex_ff[s-1].pm[63:32]) * 67'(RECIP);
            end
         end else begin : g_acc
            always_comb begin
               logic [31:0] q0;
               logic [35:0] rr;
               logic [32:0] q;
               // reciprocal estimate is at most one short: fix it by remainder
               q0 = ex_ff[s-1].pm2[65:34];
               rr = 36'(ex_ff[s-1].p) - 36'(q0) * 36'(TJ);
               q = (rr >= 36'(TJ)) ? 33'(q0) + 33'd1 : 33'(q0);
               ex_in[s] = ex_ff[s-1];
               ex_in[s].term = q;
               if (T_SUB) begin
                  ex_in[s].sum = ex_ff[s-1].sum - $signed(36'(q));
               end else begin
                  ex_in[s].sum = ex_ff[s-1].sum + $signed(36'(q));
               end
            end
         end
      end else if (s == ST_SHF) begin : g_ex_shf
         always_comb begin
            ex_in[s] = ex_ff[s-1];
            ex_in[s].expv = ex_ff[s-1].sum[35] ? '0 : (ex_ff[s-1].sum[32:0] >> ex_ff[s-1].n);
         end
      end else begin : g_ex_phi
         always_comb begin
            logic [64:0] prod65;
            prod65 = 65'(ex_ff[s-1].expv) * 65'(INV_SQRT_2PI);
            ex_in[s] = ex_ff[s-1];
            ex_in[s].phi = prod65[63:32];
         end
      end
   end

   // tail = phi * poly, clamp a negative polynomial to zero
   assign h_pos = dv_ff[ST_PHI].h[35] ? '0 : dv_ff[ST_PHI].h[34:0];
   assign tail_prod_in = 67'(ex_ff[ST_PHI].phi) * 67'(h_pos);

   always_comb begin
      logic [36:0] tail_raw;
      logic [32:0] tail_q32;
      tail_raw = tail_prod_ff[66:30];
      if (cm_ff[ST_TAIL].big) begin
         tail_q32 = '0;
      end else if (tail_raw > 37'(ONE_Q32)) begin
         tail_q32 = ONE_Q32;
      end else begin
         tail_q32 = tail_raw[32:0];
      end
      if (cm_ff[ST_TAIL].zero) begin
         n32_in = HALF_Q32;
      end else if (cm_ff[ST_TAIL].neg) begin
         n32_in = tail_q32;
      end else begin
         n32_in = ONE_Q32 - tail_q32;
      end
   end

   always_comb begin
      logic [33:0] res;
      res = (34'(n32_ff) + RND_BIAS) >> OUT_SHIFT;
      prob_in = (res > OUT_MAX) ? OUT_MAX[OUT_WIDTH-1:0] : res[OUT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ST_OUT-1:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      cm_ff[0] <= cm_in;
      for (int i = 1; i <= ST_TAIL; i++) begin
         cm_ff[i] <= cm_ff[i-1];
      end
      for (int i = 1; i <= ST_PHI; i++) begin
         dv_ff[i] <= dv_in[i];
         ex_ff[i] <= ex_in[i];
      end
      tail_prod_ff <= tail_prod_in;
      n32_ff       <= n32_in;
      prob_ff      <= prob_in;
   end

   assign rsp_strobe      = vld_ff[ST_OUT];
   assign rsp_probability = prob_ff;

endmodule

// ----- rtl/ncdf_checker.sv -----
// Port-level assertions for the normal CDF block, bound to its top level.
// Depends on ncdf_pkg and normal_cdf_approximation_defines.svh.
`include "normal_cdf_approximation_defines.svh"

module ncdf_checker #(
   parameter int IN_WIDTH  = 16,
   parameter int OUT_WIDTH = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic signed [IN_WIDTH-1:0] req_x_value,
   input logic                       rsp_strobe,
   input logic [OUT_WIDTH-1:0]       rsp_probability
);
   import ncdf_pkg::*;

   localparam logic [OUT_WIDTH-1:0] HALF_OUT = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   `NCDF_ASSERT_IMP(a_latency, clock, reset, start && !busy, ##PIPE_LATENCY rsp_strobe, "accepted beat gave no result at the fixed latency")
   `NCDF_ASSERT_IMP(a_no_orphan, clock, reset, rsp_strobe, $past(start && !busy, PIPE_LATENCY), "result without a matching accepted beat")
   `NCDF_ASSERT_IMP(a_zero_half, clock, reset, start && !busy && req_x_value == '0, ##PIPE_LATENCY rsp_probability == HALF_OUT, "zero argument did not give one half")
   `NCDF_ASSERT_NXT(a_reset_flush, clock, reset, !rsp_strobe, "result strobe after reset")

endmodule

bind normal_cdf_approximation ncdf_checker #(
   .IN_WIDTH(IN_WIDTH),
   .OUT_WIDTH(OUT_WIDTH)
) u_ncdf_checker (.*);
